// File: rtl/core/utf16be_word_to_utf8_filter_core_assert.svh
// assertion macros for the utf16be word to utf8 filter core
`ifndef UTF16BE_WORD_TO_UTF8_FILTER_CORE_ASSERT_SVH
`define UTF16BE_WORD_TO_UTF8_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define U16U8F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define U16U8F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/u16u8f_pkg.sv
// package with types and constants of the utf16be word to utf8 filter core
package u16u8f_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned CpW     = 21;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned MaxRun  = 4;
  localparam int unsigned RunIdxW = $clog2(MaxRun);

  localparam logic [LimitW-1:0] LimitReset = 7'd64;
  localparam logic [LimitW-1:0] LimitSat   = 7'd127;

  localparam logic [UnitW-1:0] HighFirst = 16'hd800;
  localparam logic [UnitW-1:0] HighLast  = 16'hdbff;
  localparam logic [UnitW-1:0] LowFirst  = 16'hdc00;
  localparam logic [UnitW-1:0] LowLast   = 16'hdfff;

  localparam logic [CpW-1:0] SuppBase  = 21'h010000;
  localparam logic [CpW-1:0] CtrlLimit = 21'h000020;
  localparam logic [CpW-1:0] DelChar   = 21'h00007f;
  localparam logic [CpW-1:0] Lim1Byte  = 21'h000080;
  localparam logic [CpW-1:0] Lim2Byte  = 21'h000800;

  localparam logic [7:0] Lead2 = 8'hc0;
  localparam logic [7:0] Lead3 = 8'he0;
  localparam logic [7:0] Lead4 = 8'hf0;
  localparam logic [7:0] Cont  = 8'h80;

  typedef enum logic [0:0] {
    REG_MAX_WORD_UNITS = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LONE_LOW = 2'd1,
    ERR_BAD_LOW  = 2'd2,
    ERR_UNTERM   = 2'd3
  } err_e;

  typedef struct packed {
    logic [9:0]        pend_high;
    logic              high_wait;
    logic [LimitW-1:0] unit_cnt;
    logic              filtered;
    logic              nonempty;
  } word_state_t;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [RunIdxW-1:0]     last_idx;
    logic                   is_byte;
    logic                   done;
    logic                   kept;
    err_e                   err;
  } run_t;

endpackage

// File: rtl/core/u16u8f_step.sv
// per-unit decode, surrogate pairing, filtering and utf8 encoding
module u16u8f_step
  import u16u8f_pkg::*;
(
  input  logic [UnitW-1:0]  unit_i,
  input  logic              end_i,
  input  logic [LimitW-1:0] max_i,
  input  word_state_t       state_i,
  output word_state_t       state_o,
  output run_t              run_o,
  output logic              run_vld_o
);

  logic              is_high;
  logic              is_low;
  logic [LimitW:0]   top_ext;
  logic [LimitW-1:0] top;
  logic [LimitW-1:0] cnt_inc;
  logic [CpW-1:0]    cp;
  logic              emit;
  logic              filt;

  assign is_high = (unit_i >= HighFirst) && (unit_i <= HighLast);
  assign is_low  = (unit_i >= LowFirst) && (unit_i <= LowLast);
  assign top_ext = {1'b0, max_i} + {{LimitW{1'b0}}, 1'b1};
  assign top     = top_ext[LimitW] ? LimitSat : top_ext[LimitW-1:0];
  assign cnt_inc = (state_i.unit_cnt < top) ? state_i.unit_cnt + 1'b1 : state_i.unit_cnt;

  always_comb begin
    state_o   = state_i;
    run_o     = '0;
    run_vld_o = 1'b0;
    emit      = 1'b0;
    filt      = 1'b0;
    cp        = '0;
    if (state_i.high_wait) begin
      if (!is_low) begin
        state_o   = '0;
        run_o.err = ERR_BAD_LOW;
        run_vld_o = 1'b1;
      end else if (end_i) begin
        state_o   = '0;
        run_o.err = ERR_UNTERM;
        run_vld_o = 1'b1;
      end else begin
        cp                 = SuppBase + {1'b0, state_i.pend_high, unit_i[9:0]};
        state_o.high_wait  = 1'b0;
        state_o.pend_high  = '0;
        state_o.unit_cnt   = cnt_inc;
        emit               = 1'b1;
      end
    end else if (unit_i == '0) begin
      state_o    = '0;
      run_o.done = 1'b1;
      run_o.kept = !state_i.filtered && state_i.nonempty;
      run_vld_o  = 1'b1;
    end else if (is_low) begin
      state_o   = '0;
      run_o.err = ERR_LONE_LOW;
      run_vld_o = 1'b1;
    end else if (is_high) begin
      if (end_i) begin
        state_o   = '0;
        run_o.err = ERR_BAD_LOW;
        run_vld_o = 1'b1;
      end else begin
        state_o.unit_cnt  = cnt_inc;
        state_o.pend_high = unit_i[9:0];
        state_o.high_wait = 1'b1;
      end
    end else if (end_i) begin
      state_o   = '0;
      run_o.err = ERR_UNTERM;
      run_vld_o = 1'b1;
    end else begin
      cp               = {{(CpW-UnitW){1'b0}}, unit_i};
      state_o.unit_cnt = cnt_inc;
      emit             = 1'b1;
    end

    if (emit) begin
      filt = state_i.filtered || (cp < CtrlLimit) || (cp == DelChar) || (cnt_inc > max_i);
      if (filt) begin
        state_o.filtered = 1'b1;
      end else begin
        state_o.nonempty = 1'b1;
        run_o.is_byte    = 1'b1;
        run_vld_o        = 1'b1;
        priority if (cp < Lim1Byte) begin
          run_o.bytes[0] = cp[7:0];
          run_o.last_idx = 2'd0;
        end else if (cp < Lim2Byte) begin
          run_o.bytes[0] = Lead2 | {3'b000, cp[10:6]};
          run_o.bytes[1] = Cont | {2'b00, cp[5:0]};
          run_o.last_idx = 2'd1;
        end else if (cp < SuppBase) begin
          run_o.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
          run_o.bytes[1] = Cont | {2'b00, cp[11:6]};
          run_o.bytes[2] = Cont | {2'b00, cp[5:0]};
          run_o.last_idx = 2'd2;
        end else begin
          run_o.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
          run_o.bytes[1] = Cont | {2'b00, cp[17:12]};
          run_o.bytes[2] = Cont | {2'b00, cp[11:6]};
          run_o.bytes[3] = Cont | {2'b00, cp[5:0]};
          run_o.last_idx = 2'd3;
        end
      end
    end
  end

endmodule

// File: rtl/core/u16u8f_ser.sv
// result register that hands out one run of results, one per transaction
module u16u8f_ser
  import u16u8f_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  run_t       run_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       word_done_o,
  output logic       word_kept_o,
  output logic [1:0] error_code_o,
  output logic       last_of_run_o
);

  run_t               run_q;
  logic               vld_q;
  logic [RunIdxW-1:0] idx_q;
  logic               pop;
  logic               last;

  assign last   = (idx_q == run_q.last_idx);
  assign pop    = vld_q && out_ready_i;
  assign free_o = !vld_q || (pop && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (pop && last) begin
      vld_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_byte_o    = run_q.is_byte ? run_q.bytes[idx_q] : 8'h00;
  assign byte_valid_o  = run_q.is_byte;
  assign word_done_o   = run_q.done;
  assign word_kept_o   = run_q.kept;
  assign error_code_o  = run_q.err;
  assign last_of_run_o = last;

endmodule

// File: rtl/core/utf16be_word_to_utf8_filter_core.sv
// an accepted unit is held in the input register; its result is then loaded into the result register
// throughput: one unit per cycle while each unit gives at most one result and the output is not stalled
// a unit giving n results holds the result register until all n are taken (4 at most)
// the result register draining one byte per transaction sets the rate
// reset: empty pipeline, word state cleared, max_word_units set to 64
// top level of the utf16be word to utf8 filter core
module utf16be_word_to_utf8_filter_core
  import u16u8f_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [UnitW-1:0]  code_unit_i,
  input  logic              data_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              word_done_o,
  output logic              word_kept_o,
  output logic [1:0]        error_code_o,
  output logic              last_of_run_o
);

  `include "utf16be_word_to_utf8_filter_core_assert.svh"

  logic [LimitW-1:0] max_q;
  logic              in_vld_q;
  logic [UnitW-1:0]  unit_q;
  logic              end_q;
  word_state_t       state_q;
  word_state_t       state_d;
  run_t              run;
  logic              run_vld;
  logic              ser_free;
  logic              fire;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PaddrW-1] == REG_MAX_WORD_UNITS);
  assign prdata  = reg_hit ? {{(PdataW-LimitW){1'b0}}, max_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_q <= pwdata[LimitW-1:0];
    end
  end

  assign fire       = in_vld_q && ser_free;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      unit_q <= code_unit_i;
      end_q  <= data_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  u16u8f_step u_step (
    .unit_i    (unit_q),
    .end_i     (end_q),
    .max_i     (max_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .run_o     (run),
    .run_vld_o (run_vld)
  );

  u16u8f_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && run_vld),
    .run_i         (run),
    .free_o        (ser_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .word_done_o   (word_done_o),
    .word_kept_o   (word_kept_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

  // non-byte results stand alone in their run
  `U16U8F_ASSERT_NOW(a_event_single, out_valid_o && !byte_valid_o, last_of_run_o, "event not last")
  // a byte run keeps going until its last byte is taken
  `U16U8F_ASSERT_NXT(a_run_cont, out_valid_o && out_ready_i && !last_of_run_o, out_valid_o, "run cut")
  // a held high surrogate has been counted
  `U16U8F_ASSERT_NOW(a_high_counted, state_q.high_wait, state_q.unit_cnt != '0, "uncounted high")
  // a verdict carries no byte and no error
  `U16U8F_ASSERT_NOW(a_verdict_clean, out_valid_o && word_done_o,
    !byte_valid_o && (error_code_o == ERR_NONE), "bad verdict")

endmodule
